@@ hw/rtl/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg
// shared types and constants of the periodic interrupt timer: request codes,
// register map and the control/status bundles between top level and channels
// ----------------------------------------------------------------------------
package pit_pkg;

  // request codes carried on the func field
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } pit_func_t;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 33;
  localparam int unsigned MCR_W  = 4;
  // channel index field of a channel-relative offset
  localparam int unsigned CH_IDX_W = 8;

  // global register map
  localparam logic [ADDR_W-1:0] ADDR_VERID   = 12'h000;
  localparam logic [ADDR_W-1:0] ADDR_PARAM   = 12'h004;
  localparam logic [ADDR_W-1:0] ADDR_MCR     = 12'h008;
  localparam logic [ADDR_W-1:0] ADDR_MSR     = 12'h00C;
  localparam logic [ADDR_W-1:0] ADDR_MIER    = 12'h010;
  localparam logic [ADDR_W-1:0] ADDR_SETTEN  = 12'h014;
  localparam logic [ADDR_W-1:0] ADDR_CLRTEN  = 12'h018;
  localparam logic [ADDR_W-1:0] ADDR_CH_BASE = 12'h020;

  // per-channel register offsets (channel span is 0x10)
  localparam logic [3:0] CH_RELOAD = 4'h0;
  localparam logic [3:0] CH_COUNT  = 4'h4;
  localparam logic [3:0] CH_CTRL   = 4'h8;

  localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0100_0000;

  // module control bits
  localparam int unsigned MCR_ENABLE_BIT = 0;
  localparam int unsigned MCR_SWRST_BIT  = 1;
  // channel control bits
  localparam int unsigned CTRL_EN_BIT    = 0;

  // commands to one channel, already qualified by the accepted request
  typedef struct packed {
    logic              tick;
    logic              wr_reload;
    logic              wr_ctrl;
    logic              set_en;
    logic              clr_en;
    logic              swrst;
    logic              mod_en;
    logic [DATA_W-1:0] wdata;
  } pit_chan_cmd_t;

  // state seen from the bus plus the expiry strobe
  typedef struct packed {
    logic [DATA_W-1:0] reload;
    logic [DATA_W-1:0] ctrl;
    logic [DATA_W-1:0] count;
    logic              expire;
  } pit_chan_stat_t;

endpackage

@@ hw/rtl/pit_channel.sv @@
// ----------------------------------------------------------------------------
// pit_channel
// one timer channel: reload value, control word, 33-bit down-counter and
// running flag, updated once per accepted request
// ----------------------------------------------------------------------------
module pit_channel
  import pit_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  pit_chan_cmd_t  cmd,
  output pit_chan_stat_t stat
);

  logic [DATA_W-1:0] reload_r, reload_nxt;
  logic [DATA_W-1:0] ctrl_r, ctrl_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              run_r, run_nxt;
  logic [CNT_W-1:0]  reload_p1;
  logic              start;
  logic              expire;

  assign reload_p1 = {1'b0, reload_r} + CNT_W'(1);

  always_comb begin
    reload_nxt = reload_r;
    ctrl_nxt   = ctrl_r;
    count_nxt  = count_r;
    run_nxt    = run_r;
    start      = 1'b0;
    expire     = 1'b0;

    if (cmd.swrst) begin
      reload_nxt = '0;
      ctrl_nxt   = '0;
      run_nxt    = 1'b0;
    end
    if (cmd.wr_reload) begin
      reload_nxt = cmd.wdata;
    end
    if (cmd.wr_ctrl) begin
      ctrl_nxt = cmd.wdata;
      // rising enable starts, falling enable stops
      if (cmd.wdata[CTRL_EN_BIT] && !ctrl_r[CTRL_EN_BIT]) begin
        start = 1'b1;
      end else if (!cmd.wdata[CTRL_EN_BIT] && ctrl_r[CTRL_EN_BIT]) begin
        run_nxt = 1'b0;
      end
    end
    if (cmd.set_en) begin
      ctrl_nxt[CTRL_EN_BIT] = 1'b1;
      start                 = 1'b1;
    end
    if (cmd.clr_en) begin
      ctrl_nxt[CTRL_EN_BIT] = 1'b0;
      run_nxt               = 1'b0;
    end
    if (start) begin
      if (cmd.mod_en) begin
        count_nxt = reload_p1;
        run_nxt   = 1'b1;
      end else begin
        run_nxt = 1'b0;
      end
    end
    if (cmd.tick && run_r) begin
      if (count_r <= CNT_W'(1)) begin
        expire    = 1'b1;
        count_nxt = reload_p1;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '0;
      ctrl_r   <= '0;
      count_r  <= '0;
      run_r    <= 1'b0;
    end else begin
      reload_r <= reload_nxt;
      ctrl_r   <= ctrl_nxt;
      count_r  <= count_nxt;
      run_r    <= run_nxt;
    end
  end

  assign stat.reload = reload_r;
  assign stat.ctrl   = ctrl_r;
  assign stat.count  = count_r[DATA_W-1:0];
  assign stat.expire = expire;

endmodule

@@ hw/rtl/periodic_interrupt_timer.sv @@
// ----------------------------------------------------------------------------
// periodic_interrupt_timer
// multi-channel periodic interrupt timer with a request-per-cycle interface
// ----------------------------------------------------------------------------
// Each request is a bus read, a bus write or one peripheral-clock tick, and
// each request yields exactly one result (read data, zero for writes and
// ticks, and the interrupt line as it stands after the request). The block
// takes one request every cycle while the receiver keeps up. A result is
// offered after its request leaves the input register, where the address
// decode and the per-channel counter update happen, and then waits in the
// result register until the receiver takes it. The result register and the
// input register together let a new request in while an earlier result is
// still stalled. Channels count down on tick requests only and set their
// status flag when the period of reload + 1 ticks elapses.
// ----------------------------------------------------------------------------
module periodic_interrupt_timer
  import pit_pkg::*;
#(
  parameter int unsigned N_CHAN = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [DATA_W-1:0] in_wdata,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_rdata,
  output logic              out_irq
);

  // input register
  logic              s1_valid_r;
  logic [1:0]        s1_func_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_wdata_r;

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_rdata_r, out_rdata_nxt;
  logic              out_irq_r, out_irq_nxt;

  // global registers
  logic [MCR_W-1:0]  mcr_r, mcr_nxt;
  logic [N_CHAN-1:0] status_r, status_nxt;
  logic [N_CHAN-1:0] ien_r, ien_nxt;

  logic s1_adv;
  logic s1_fire;
  logic is_rd, is_wr, is_tick;
  logic wr_mcr, wr_msr, wr_mier, wr_setten, wr_clrten, swrst;

  // channel-relative decode
  logic [ADDR_W-1:0]   ch_off;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [3:0]          ch_reg;
  logic                chan_hit;

  pit_chan_cmd_t     chan_cmd  [N_CHAN];
  pit_chan_stat_t    chan_stat [N_CHAN];
  logic [N_CHAN-1:0] expire_vec;
  logic [N_CHAN-1:0] en_mask;
  logic [DATA_W-1:0] chan_rdata;

  // the request in the input register moves on when the result slot is free
  assign s1_adv    = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s1_adv;
  // a request is refused only while the input register holds one that cannot move
  assign in_stall  = s1_valid_r && !s1_adv;
  assign out_valid = out_valid_r;
  assign out_rdata = out_rdata_r;
  assign out_irq   = out_irq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r  <= in_func;
      s1_addr_r  <= in_addr;
      s1_wdata_r <= in_wdata;
    end
  end

  // request decode
  assign is_rd   = s1_fire && (s1_func_r == FUNC_READ);
  assign is_wr   = s1_fire && (s1_func_r == FUNC_WRITE);
  assign is_tick = s1_fire && (s1_func_r == FUNC_TICK);

  assign wr_mcr    = is_wr && (s1_addr_r == ADDR_MCR);
  assign wr_msr    = is_wr && (s1_addr_r == ADDR_MSR);
  assign wr_mier   = is_wr && (s1_addr_r == ADDR_MIER);
  assign wr_setten = is_wr && (s1_addr_r == ADDR_SETTEN);
  assign wr_clrten = is_wr && (s1_addr_r == ADDR_CLRTEN);
  assign swrst     = wr_mcr && s1_wdata_r[MCR_SWRST_BIT];

  // channel window starts at the channel base, 0x10 bytes per channel
  assign ch_off   = s1_addr_r - ADDR_CH_BASE;
  assign ch_idx   = ch_off[ADDR_W-1:4];
  assign ch_reg   = ch_off[3:0];
  assign chan_hit = (s1_addr_r >= ADDR_CH_BASE) && (ch_idx < CH_IDX_W'(N_CHAN));

  // per-channel command bundles and the channel lanes
  for (genvar g = 0; g < N_CHAN; g++) begin : g_chan
    logic sel;

    assign sel = chan_hit && (ch_idx == CH_IDX_W'(g));

    assign chan_cmd[g].tick      = is_tick;
    assign chan_cmd[g].wr_reload = is_wr && sel && (ch_reg == CH_RELOAD);
    assign chan_cmd[g].wr_ctrl   = is_wr && sel && (ch_reg == CH_CTRL);
    assign chan_cmd[g].set_en    = wr_setten && s1_wdata_r[g];
    assign chan_cmd[g].clr_en    = wr_clrten && s1_wdata_r[g];
    assign chan_cmd[g].swrst     = swrst;
    assign chan_cmd[g].mod_en    = mcr_r[MCR_ENABLE_BIT];
    assign chan_cmd[g].wdata     = s1_wdata_r;

    pit_channel u_channel (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (chan_cmd[g]),
      .stat  (chan_stat[g])
    );

    assign expire_vec[g] = chan_stat[g].expire;
    assign en_mask[g]    = chan_stat[g].ctrl[CTRL_EN_BIT];
  end

  // global register updates; software reset wins over the flag clear
  always_comb begin
    mcr_nxt    = mcr_r;
    ien_nxt    = ien_r;
    status_nxt = status_r | expire_vec;
    if (wr_mcr) begin
      mcr_nxt = s1_wdata_r[MCR_W-1:0];
    end
    if (wr_mier) begin
      ien_nxt = s1_wdata_r[N_CHAN-1:0];
    end
    if (wr_msr) begin
      status_nxt = status_r & ~s1_wdata_r[N_CHAN-1:0];
    end
    if (swrst) begin
      status_nxt = '0;
    end
  end

  // channel register read, one lane selected by the decoded index
  always_comb begin
    chan_rdata = '0;
    for (int i = 0; i < N_CHAN; i++) begin
      if (ch_idx == CH_IDX_W'(i)) begin
        unique case (ch_reg)
          CH_RELOAD: chan_rdata = chan_stat[i].reload;
          CH_COUNT:  chan_rdata = chan_stat[i].count;
          CH_CTRL:   chan_rdata = chan_stat[i].ctrl;
          default:   chan_rdata = '0;
        endcase
      end
    end
  end

  // read mux; unknown offsets read as zero
  always_comb begin
    out_rdata_nxt = '0;
    if (is_rd) begin
      unique case (s1_addr_r)
        ADDR_VERID:  out_rdata_nxt = VERSION_WORD;
        ADDR_PARAM:  out_rdata_nxt = DATA_W'(N_CHAN);
        ADDR_MCR:    out_rdata_nxt = DATA_W'(mcr_r);
        ADDR_MSR:    out_rdata_nxt = DATA_W'(status_r);
        ADDR_MIER:   out_rdata_nxt = DATA_W'(ien_r);
        ADDR_SETTEN: out_rdata_nxt = DATA_W'(en_mask);
        ADDR_CLRTEN: out_rdata_nxt = DATA_W'(en_mask);
        default:     out_rdata_nxt = chan_hit ? chan_rdata : '0;
      endcase
    end
  end

  // interrupt line as it stands after this request
  assign out_irq_nxt = |(status_nxt & ien_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcr_r    <= '0;
      status_r <= '0;
      ien_r    <= '0;
    end else begin
      mcr_r    <= mcr_nxt;
      status_r <= status_nxt;
      ien_r    <= ien_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_rdata_r <= out_rdata_nxt;
      out_irq_r   <= out_irq_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a request leaving the input register always lands in the result register
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("request lost between input and result register");

  // reported interrupt matches the flags and enables it was taken from
  a_irq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_irq_r == |(status_r & ien_r)))
    else $error("interrupt line out of step with flags and enables");

  // software reset leaves no status flag set
  a_swrst_clears: assert property (@(posedge clk) disable iff (!rst_n)
    swrst |=> (status_r == '0))
    else $error("status flags survived software reset");

  // flags only change on an accepted request
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(status_r))
    else $error("status flags changed with no request");
`endif

endmodule

@@ tb/sv/tb_periodic_interrupt_timer.sv @@
// ----------------------------------------------------------------------------
// tb_periodic_interrupt_timer
// self-checking regression of the four-channel periodic interrupt timer
// ----------------------------------------------------------------------------
// Requests (bus reads, bus writes and peripheral-clock ticks) go in over a
// valid/stall channel. Each accepted request is run through a local timer
// model, which holds its own copy of every register, counter and flag. The
// model's read data and interrupt line join a queue, and every result the
// block hands out is checked against the head of that queue. Directed tests
// cover the register map, the channel period, the start rules, counter
// truncation and software reset. A long receiver hold-off fills the
// pipeline, and random traffic with phased idling on both sides follows.
// ----------------------------------------------------------------------------
module tb_periodic_interrupt_timer
  import pit_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH     = 4;
  localparam int unsigned CH_SPAN = 16;
  localparam int unsigned MAX_GAP = 12;

  // func code that the block must treat as a no-op
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // channel offset with no register behind it
  localparam logic [3:0] CH_UNUSED = 4'hC;

  localparam logic [DATA_W-1:0] MCR_RUN   = 32'd1 << MCR_ENABLE_BIT;
  localparam logic [DATA_W-1:0] MCR_RESET = 32'd1 << MCR_SWRST_BIT;
  localparam logic [DATA_W-1:0] CTRL_ON   = 32'd1 << CTRL_EN_BIT;

  localparam logic [ADDR_W-1:0] GLOBAL_REGS [7] = '{ADDR_VERID, ADDR_PARAM, ADDR_MCR,
                                                    ADDR_MSR, ADDR_MIER, ADDR_SETTEN,
                                                    ADDR_CLRTEN};
  localparam logic [3:0] CHAN_REGS [3] = '{CH_RELOAD, CH_COUNT, CH_CTRL};

  // one expected result, with the request that caused it for the log
  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] rdata;
    logic              irq;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_func;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_wdata;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_rdata;
  logic              out_irq;

  // timer model state
  logic [MCR_W-1:0]  tm_mcr;
  logic [NCH-1:0]    tm_flags;
  logic [NCH-1:0]    tm_ien;
  logic [DATA_W-1:0] tm_reload [NCH];
  logic [DATA_W-1:0] tm_ctrl   [NCH];
  logic [CNT_W-1:0]  tm_count  [NCH];
  logic [NCH-1:0]    tm_run;

  timer_result_t result_q [$];
  timer_result_t head_res;

  // idling knobs, and a one-off receiver hold-off in cycles
  bit          tx_idle;
  bit          rx_idle;
  int unsigned rx_hold;

  int unsigned err_count;
  int unsigned n_ticks, n_reads, n_writes, n_other;
  int unsigned n_results, n_expiries, n_in_stalls;

  always #2 clk = ~clk;

  periodic_interrupt_timer #(
    .N_CHAN(NCH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_addr  (in_addr),
    .in_wdata (in_wdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rdata(out_rdata),
    .out_irq  (out_irq)
  );

  // --------------------------------------------------------------------------
  // timer model
  // --------------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] chan_addr(int unsigned ch, logic [3:0] rsel);
    return ADDR_CH_BASE + ADDR_W'(ch * CH_SPAN) + ADDR_W'(rsel);
  endfunction

  function automatic void timer_clear();
    tm_mcr   = '0;
    tm_flags = '0;
    tm_ien   = '0;
    tm_run   = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      tm_reload[ch] = '0;
      tm_ctrl[ch]   = '0;
      tm_count[ch]  = '0;
    end
  endfunction

  // a start only runs the channel while the module enable is set
  function automatic void timer_start(int ch);
    if (tm_mcr[MCR_ENABLE_BIT]) begin
      tm_count[ch] = {1'b0, tm_reload[ch]} + CNT_W'(1);
      tm_run[ch]   = 1'b1;
    end else begin
      tm_run[ch] = 1'b0;
    end
  endfunction

  function automatic logic [NCH-1:0] enabled_chans();
    logic [NCH-1:0] m;
    for (int ch = 0; ch < NCH; ch++) m[ch] = tm_ctrl[ch][CTRL_EN_BIT];
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] timer_read(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off;
    int unsigned       ch;
    off = a - ADDR_CH_BASE;
    ch  = 32'(off[ADDR_W-1:4]);
    case (a)
      ADDR_VERID:               return VERSION_WORD;
      ADDR_PARAM:               return DATA_W'(NCH);
      ADDR_MCR:                 return DATA_W'(tm_mcr);
      ADDR_MSR:                 return DATA_W'(tm_flags);
      ADDR_MIER:                return DATA_W'(tm_ien);
      ADDR_SETTEN, ADDR_CLRTEN: return DATA_W'(enabled_chans());
      default: ;
    endcase
    if (a >= ADDR_CH_BASE && ch < NCH) begin
      case (off[3:0])
        CH_RELOAD: return tm_reload[ch];
        CH_COUNT:  return tm_count[ch][DATA_W-1:0];
        CH_CTRL:   return tm_ctrl[ch];
        default: ;
      endcase
    end
    return '0;
  endfunction

  function automatic void timer_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    logic [ADDR_W-1:0] off;
    int unsigned       ch;
    logic              was_on;
    off = a - ADDR_CH_BASE;
    ch  = 32'(off[ADDR_W-1:4]);
    case (a)
      ADDR_MCR: begin
        tm_mcr = d[MCR_W-1:0];
        if (d[MCR_SWRST_BIT]) begin
          tm_flags = '0;
          tm_run   = '0;
          for (int i = 0; i < NCH; i++) begin
            tm_reload[i] = '0;
            tm_ctrl[i]   = '0;
          end
        end
      end
      ADDR_MSR:  tm_flags = tm_flags & ~d[NCH-1:0];
      ADDR_MIER: tm_ien = d[NCH-1:0];
      ADDR_SETTEN: begin
        for (int i = 0; i < NCH; i++) begin
          if (d[i]) begin
            tm_ctrl[i][CTRL_EN_BIT] = 1'b1;
            timer_start(i);
          end
        end
      end
      ADDR_CLRTEN: begin
        for (int i = 0; i < NCH; i++) begin
          if (d[i]) begin
            tm_ctrl[i][CTRL_EN_BIT] = 1'b0;
            tm_run[i] = 1'b0;
          end
        end
      end
      default: begin
        if (a >= ADDR_CH_BASE && ch < NCH) begin
          if (off[3:0] == CH_RELOAD) begin
            tm_reload[ch] = d;
          end else if (off[3:0] == CH_CTRL) begin
            was_on = tm_ctrl[ch][CTRL_EN_BIT];
            tm_ctrl[ch] = d;
            if (d[CTRL_EN_BIT] && !was_on) timer_start(ch);
            else if (!d[CTRL_EN_BIT] && was_on) tm_run[ch] = 1'b0;
          end
        end
      end
    endcase
  endfunction

  function automatic void timer_tick();
    for (int ch = 0; ch < NCH; ch++) begin
      if (tm_run[ch]) begin
        if (tm_count[ch] <= CNT_W'(1)) begin
          tm_flags[ch] = 1'b1;
          tm_count[ch] = {1'b0, tm_reload[ch]} + CNT_W'(1);
          n_expiries++;
        end else begin
          tm_count[ch] = tm_count[ch] - CNT_W'(1);
        end
      end
    end
  endfunction

  function automatic timer_result_t timer_predict(logic [1:0] f, logic [ADDR_W-1:0] a,
                                                  logic [DATA_W-1:0] d);
    timer_result_t r;
    r.func  = f;
    r.addr  = a;
    r.rdata = '0;
    case (f)
      FUNC_READ:  r.rdata = timer_read(a);
      FUNC_WRITE: timer_write(a, d);
      FUNC_TICK:  timer_tick();
      default: ;
    endcase
    r.irq = |(tm_flags & tm_ien);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // called just after a rising edge; returns just after the edge that took it
  task automatic send_request(input logic [1:0] f, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
    int unsigned gap;
    bit          taken;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_addr  <= a;
    in_wdata <= d;
    // stall is settled by the falling edge, so it tells what the next edge does
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (!taken) n_in_stalls++;
      @(posedge clk);
    end while (!taken);
    result_q.push_back(timer_predict(f, a, d));
    case (f)
      FUNC_READ:  n_reads++;
      FUNC_WRITE: n_writes++;
      FUNC_TICK:  n_ticks++;
      default:    n_other++;
    endcase
  endtask

  // mostly well-formed traffic with small reload values so channels expire
  // often; a slice of full-range noise on every field
  task automatic send_random_request();
    int unsigned       pick;
    int unsigned       ch;
    logic [1:0]        f;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 99);
    ch   = $urandom_range(0, NCH - 1);
    d    = $urandom;
    f    = FUNC_WRITE;
    a    = ADDR_MSR;
    if (pick < 45) begin
      f = FUNC_TICK;
    end else if (pick < 58) begin
      a = chan_addr(ch, CH_RELOAD);
      if ($urandom_range(0, 15) != 0) d = $urandom_range(0, 12);
    end else if (pick < 66) begin
      a = chan_addr(ch, CH_CTRL);
    end else if (pick < 70) begin
      a = ADDR_MCR;
      d[MCR_ENABLE_BIT] = ($urandom_range(0, 4) != 0);
      d[MCR_SWRST_BIT]  = ($urandom_range(0, 19) == 0);
    end else if (pick < 73) begin
      a = ADDR_MSR;
    end else if (pick < 76) begin
      a = ADDR_MIER;
    end else if (pick < 80) begin
      a = $urandom_range(0, 1) ? ADDR_SETTEN : ADDR_CLRTEN;
    end else if (pick < 92) begin
      f = FUNC_READ;
      if ($urandom_range(0, 1)) a = chan_addr(ch, CHAN_REGS[$urandom_range(0, 2)]);
      else a = GLOBAL_REGS[$urandom_range(0, 6)];
    end else begin
      f = 2'($urandom_range(0, 3));
      a = ADDR_W'($urandom_range(0, 4095));
    end
    send_request(f, a, d);
  endtask

  // stop offering, wait for every outstanding result, then settle
  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && result_q.size() != 0; i++) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // receiver stall pattern, with an optional long hold-off
  initial begin : result_sink
    int unsigned wait_n;
    bit          took;
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        wait_n  = rx_hold;
        rx_hold = 0;
      end else begin
        wait_n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took && rx_hold == 0);
    end
  end

  // result checker, sampled mid-cycle where everything has settled
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual rdata %h irq %b",
                 $time, out_rdata, out_irq);
      end else begin
        head_res = result_q.pop_front();
        if (out_rdata !== head_res.rdata) begin
          err_count++;
          $display("%0t: rdata mismatch (func %0d addr %h), expected %h, actual %h",
                   $time, head_res.func, head_res.addr, head_res.rdata, out_rdata);
        end
        if (out_irq !== head_res.irq) begin
          err_count++;
          $display("%0t: irq mismatch (func %0d addr %h), expected %b, actual %b",
                   $time, head_res.func, head_res.addr, head_res.irq, out_irq);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // fixed words, holes in the map and the unused func code
  task automatic test_register_map();
    send_request(FUNC_READ, ADDR_VERID, '1);
    send_request(FUNC_READ, ADDR_PARAM, '0);
    // channel beyond the last one, the spare slot and an unaligned offset
    send_request(FUNC_READ, chan_addr(NCH, CH_RELOAD), '0);
    send_request(FUNC_READ, chan_addr(0, CH_UNUSED), '0);
    send_request(FUNC_WRITE, chan_addr(1, CH_RELOAD) + ADDR_W'(1), '1);
    send_request(FUNC_READ, chan_addr(1, CH_RELOAD), '0);
    send_request(FUNC_READ, '1, '0);
    send_request(FUNC_UNUSED, ADDR_MCR, '1);
  endtask

  // one channel with period 2, interrupt raised then cleared by write-one
  task automatic test_period_and_irq();
    send_request(FUNC_WRITE, ADDR_MIER, '1);
    send_request(FUNC_WRITE, ADDR_MCR, MCR_RUN);
    send_request(FUNC_WRITE, chan_addr(0, CH_RELOAD), 32'd1);
    send_request(FUNC_WRITE, chan_addr(0, CH_CTRL), CTRL_ON);
    send_request(FUNC_TICK, '0, '0);
    send_request(FUNC_TICK, '0, '0);
    send_request(FUNC_READ, ADDR_MSR, '0);
    send_request(FUNC_WRITE, ADDR_MSR, '1);
  endtask

  // module enable off: running channels carry on, new starts do not run;
  // re-writing an already set enable bit is no start; reload change waits
  task automatic test_start_rules();
    send_request(FUNC_WRITE, ADDR_MCR, '0);
    send_request(FUNC_TICK, '0, '0);
    send_request(FUNC_WRITE, ADDR_SETTEN, 32'hFFFF_FFF2);
    send_request(FUNC_WRITE, ADDR_MCR, MCR_RUN);
    send_request(FUNC_WRITE, chan_addr(1, CH_CTRL), CTRL_ON);
    send_request(FUNC_READ, chan_addr(1, CH_COUNT), '0);
    send_request(FUNC_WRITE, ADDR_SETTEN, 32'd2);
    send_request(FUNC_WRITE, chan_addr(1, CH_RELOAD), 32'd9);
    send_request(FUNC_TICK, '0, '0);
    send_request(FUNC_READ, chan_addr(1, CH_COUNT), '0);
    send_request(FUNC_WRITE, ADDR_CLRTEN, 32'd1);
    send_request(FUNC_READ, ADDR_CLRTEN, '0);
  endtask

  // full-range reload: the 33-bit counter reads back as its low 32 bits
  task automatic test_count_truncation();
    send_request(FUNC_WRITE, chan_addr(3, CH_RELOAD), '1);
    send_request(FUNC_WRITE, chan_addr(3, CH_CTRL), CTRL_ON);
    send_request(FUNC_READ, chan_addr(3, CH_COUNT), '0);
    send_request(FUNC_TICK, '0, '0);
    send_request(FUNC_READ, chan_addr(3, CH_COUNT), '0);
  endtask

  // software reset clears flags, reloads and controls; counters freeze
  task automatic test_soft_reset();
    send_request(FUNC_WRITE, ADDR_MCR, MCR_RESET | MCR_RUN);
    send_request(FUNC_READ, ADDR_MCR, '0);
    send_request(FUNC_TICK, '0, '0);
    send_request(FUNC_READ, chan_addr(3, CH_COUNT), '0);
  endtask

  // receiver holds off while the sender keeps pushing, so the block fills
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 80;
    repeat (30) send_random_request();
  endtask

  // random traffic in phases, stepping through every idling combination
  task automatic test_random_traffic();
    for (int phase = 0; phase < 23; phase++) begin
      tx_idle = (phase % 2) != 0;
      rx_idle = ((phase / 2) % 2) != 0;
      repeat (50) send_random_request();
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_READ;
    in_addr  = '0;
    in_wdata = '0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    rx_hold  = 0;
    timer_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_register_map();
    test_period_and_irq();
    test_start_rules();
    test_count_truncation();
    test_soft_reset();
    drain(0);
    test_backpressure();
    drain(0);
    test_random_traffic();
    // wait for the outstanding results, then allow some slack
    drain(8);

    if (result_q.size() != 0) begin
      err_count += result_q.size();
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
    end

    $display("run covered %0d reads, %0d writes, %0d ticks and %0d no-op requests",
             n_reads, n_writes, n_ticks, n_other);
    $display("%0d results checked, %0d channel expiries, %0d input stall cycles",
             n_results, n_expiries, n_in_stalls);
    if (err_count == 0) begin
      $display("periodic_interrupt_timer regression: pass");
    end else begin
      $display("periodic_interrupt_timer regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legitimate run
  initial begin
    #2_000_000;
    $display("periodic_interrupt_timer regression: fail");
    $finish;
  end

endmodule
